@@ hw/rtl/tbi_pkg.sv @@
package tbi_pkg;

  // table geometry
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam logic [CNT_W-1:0] CNT_RESET = 5'd2;
  localparam logic [CNT_W-1:0] CNT_MIN   = 5'd2;
  localparam logic [CNT_W-1:0] CNT_MAX   = 5'(MAX_ENTRIES);

  // field widths
  localparam int ALT_W   = 23;
  localparam int PITCH_W = 19;
  localparam int QALT_W  = 24;
  localparam int REG_W   = 2;
  localparam int ENTRY_W = ALT_W + PITCH_W;

  // stream widths
  localparam int S_TDATA_W  = 72;
  localparam int S_FIELDS_W = IDX_W + ALT_W + PITCH_W + QALT_W;
  localparam int M_TDATA_W  = 32;
  localparam int M_FIELDS_W = PITCH_W + IDX_W + REG_W;
  localparam int OUT_PAD_W  = M_TDATA_W - M_FIELDS_W;

  // interpolation datapath
  localparam int DIFF_W    = PITCH_W + 1;
  localparam int PROD_W    = ALT_W + PITCH_W;
  localparam int DIV_STEPS = 20;
  localparam int DCNT_W    = 5;

  // request queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QA_W        = 2;

  // command codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // region codes
  localparam logic [REG_W-1:0] REGION_INTERP = 2'd0;
  localparam logic [REG_W-1:0] REGION_BELOW  = 2'd1;
  localparam logic [REG_W-1:0] REGION_ABOVE  = 2'd2;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          idx;
    logic [ALT_W-1:0]          alt;
    logic signed [PITCH_W-1:0] pitch;
    logic signed [QALT_W-1:0]  qalt;
  } item_t;

endpackage

@@ hw/rtl/tracked_breakpoint_interpolator.sv @@
// a write goes through the front register and the queue into the table
// a query goes to its result through table reads with a registered port, one multiply and a
// 20-step restoring divider; clamped results and flat segments skip multiply and divide
// the back end takes no new request until the current result is registered for output
// the front stage and a 4-entry queue keep taking requests while the back end works
// reset: synchronous, active high; clears handshakes, queue, segment and sets count to 2
module tracked_breakpoint_interpolator (
  input  logic                          clk,
  input  logic                          rst,
  // request stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // entry_index, entry_altitude, entry_pitch, query_altitude, zero pad
  input  logic [tbi_pkg::S_TDATA_W-1:0] s_tdata,
  // cmd
  input  logic                          s_tuser,
  // result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // target_pitch, segment, region, zero pad
  output logic [tbi_pkg::M_TDATA_W-1:0] m_tdata,
  // entry count register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tbi_pkg::CNT_W-1:0]     cfg_data
);

  logic [tbi_pkg::CNT_W-1:0] entry_count;

  // front to queue
  logic           push_valid;
  logic           push_ready;
  tbi_pkg::item_t push_item;

  // queue to back end
  logic           pop_valid;
  logic           pop_ready;
  tbi_pkg::item_t pop_item;

  // the count register takes a write in any cycle
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= tbi_pkg::CNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      entry_count <= cfg_data;
    end
  end

  // front: takes each request and decodes write vs query
  tbi_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  // short queue so front and back stall independently
  tbi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  // back end: table writes, segment walk, interpolation, result register
  tbi_back u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_count (entry_count),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_item    (pop_item),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

@@ hw/rtl/tbi_front.sv @@
module tbi_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [tbi_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                           s_tuser,
  output logic                           push_valid,
  input  logic                           push_ready,
  output tbi_pkg::item_t                 push_item
);

  logic           held;
  tbi_pkg::item_t item;
  tbi_pkg::item_t item_next;

  assign s_tready   = !held || push_ready;
  assign push_valid = held;
  assign push_item  = item;

  // decode the request and keep only the fields its kind uses
  always_comb begin
    item_next       = '0;
    item_next.op    = s_tuser;
    if (s_tuser == tbi_pkg::OP_WRITE) begin
      item_next.idx   = s_tdata[tbi_pkg::IDX_W-1:0];
      item_next.alt   = s_tdata[tbi_pkg::IDX_W +: tbi_pkg::ALT_W];
      item_next.pitch = s_tdata[tbi_pkg::IDX_W+tbi_pkg::ALT_W +: tbi_pkg::PITCH_W];
    end else begin
      item_next.qalt  = s_tdata[tbi_pkg::IDX_W+tbi_pkg::ALT_W+tbi_pkg::PITCH_W +:
                                tbi_pkg::QALT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      held <= 1'b1;
    end else if (push_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item <= item_next;
    end
  end

endmodule

@@ hw/rtl/tbi_queue.sv @@
module tbi_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  tbi_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output tbi_pkg::item_t pop_item
);

  tbi_pkg::item_t            slots [tbi_pkg::QUEUE_DEPTH];
  logic [tbi_pkg::QA_W-1:0]  wr_ptr;
  logic [tbi_pkg::QA_W-1:0]  rd_ptr;
  logic [tbi_pkg::QA_W:0]    fill;
  logic                      do_push;
  logic                      do_pop;

  assign push_ready = fill != (tbi_pkg::QA_W+1)'(tbi_pkg::QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hw/rtl/tbi_back.sv @@
module tbi_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tbi_pkg::CNT_W-1:0]     entry_count,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  tbi_pkg::item_t                pop_item,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tbi_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0] state;

  // breakpoint table: altitude above pitch
  logic [tbi_pkg::ENTRY_W-1:0] tbl [tbi_pkg::MAX_ENTRIES];
  logic [tbi_pkg::ENTRY_W-1:0] rd0;
  logic [tbi_pkg::ENTRY_W-1:0] rd1;

  logic [tbi_pkg::IDX_W-1:0]        cur_seg;
  logic [tbi_pkg::IDX_W-1:0]        seg_p1;
  logic [tbi_pkg::CNT_W-1:0]        n_used;
  logic [tbi_pkg::CNT_W-1:0]        n_clamp;
  logic [tbi_pkg::CNT_W-1:0]        n_m2;
  logic                             walk_down;
  logic signed [tbi_pkg::QALT_W-1:0] qalt;

  logic [tbi_pkg::ALT_W-1:0]          alt0;
  logic [tbi_pkg::ALT_W-1:0]          alt1;
  logic signed [tbi_pkg::PITCH_W-1:0] p0;
  logic signed [tbi_pkg::PITCH_W-1:0] p1;
  logic signed [tbi_pkg::QALT_W:0]    a_ext;
  logic signed [tbi_pkg::QALT_W:0]    alt0_ext;
  logic signed [tbi_pkg::QALT_W:0]    alt1_ext;
  logic signed [tbi_pkg::QALT_W:0]    da_full;
  logic                               up_ok;
  logic                               dn_ok;

  logic [tbi_pkg::ALT_W-1:0]          da;
  logic [tbi_pkg::ALT_W-1:0]          dalt;
  logic signed [tbi_pkg::DIFF_W-1:0]  dp;
  logic [tbi_pkg::DIFF_W-1:0]         dp_neg;
  logic [tbi_pkg::PITCH_W-1:0]        dp_mag;
  logic [tbi_pkg::PROD_W-1:0]         prod;
  logic                               neg;

  logic [tbi_pkg::ALT_W-1:0]      rem;
  logic [tbi_pkg::DIV_STEPS-1:0]  wq;
  logic [tbi_pkg::DCNT_W-1:0]     dcnt;
  logic [tbi_pkg::ALT_W:0]        trial;
  logic [tbi_pkg::ALT_W:0]        trial_sub;
  logic                           ge;
  logic signed [tbi_pkg::DIFF_W-1:0] quo;
  logic signed [tbi_pkg::DIFF_W-1:0] sum;

  logic signed [tbi_pkg::PITCH_W-1:0] res_pitch;
  logic [tbi_pkg::REG_W-1:0]          res_region;
  logic                               out_free;

  assign pop_ready = state == ST_IDLE;
  assign out_free  = !m_tvalid || m_tready;
  assign seg_p1    = cur_seg + 1'b1;

  // count clamped to the table
  always_comb begin
    priority if (entry_count < tbi_pkg::CNT_MIN) begin
      n_clamp = tbi_pkg::CNT_MIN;
    end else if (entry_count > tbi_pkg::CNT_MAX) begin
      n_clamp = tbi_pkg::CNT_MAX;
    end else begin
      n_clamp = entry_count;
    end
  end
  assign n_m2 = n_clamp - tbi_pkg::CNT_MIN;

  assign alt0     = rd0[tbi_pkg::ENTRY_W-1 -: tbi_pkg::ALT_W];
  assign alt1     = rd1[tbi_pkg::ENTRY_W-1 -: tbi_pkg::ALT_W];
  assign p0       = rd0[tbi_pkg::PITCH_W-1:0];
  assign p1       = rd1[tbi_pkg::PITCH_W-1:0];
  assign a_ext    = {qalt[tbi_pkg::QALT_W-1], qalt};
  assign alt0_ext = {2'b00, alt0};
  assign alt1_ext = {2'b00, alt1};
  assign da_full  = a_ext - alt0_ext;

  // walk conditions for the segment held in cur_seg
  assign up_ok = (({1'b0, cur_seg} + 5'd2) < n_used) && (alt1_ext <= a_ext);
  assign dn_ok = (cur_seg != '0) && (alt0_ext > a_ext);

  assign dp_neg = -dp;
  assign dp_mag = dp[tbi_pkg::DIFF_W-1] ? dp_neg[tbi_pkg::PITCH_W-1:0]
                                        : dp[tbi_pkg::PITCH_W-1:0];
  assign prod   = da * dp_mag;

  // one restoring step per cycle
  assign trial     = {rem, wq[tbi_pkg::DIV_STEPS-1]};
  assign ge        = trial >= {1'b0, dalt};
  assign trial_sub = trial - {1'b0, dalt};

  assign quo = neg ? -$signed(wq) : $signed(wq);
  assign sum = {p0[tbi_pkg::PITCH_W-1], p0} + quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_seg   <= '0;
      walk_down <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop_valid && pop_item.op == tbi_pkg::OP_QUERY) begin
            walk_down <= 1'b0;
            if ({1'b0, cur_seg} > n_m2) begin
              cur_seg <= n_m2[tbi_pkg::IDX_W-1:0];
            end
            state <= ST_RD;
          end
        end
        ST_RD: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          priority if (!walk_down && up_ok) begin
            cur_seg <= seg_p1;
            state   <= ST_RD;
          end else if (dn_ok) begin
            walk_down <= 1'b1;
            cur_seg   <= cur_seg - 1'b1;
            state     <= ST_RD;
          end else if (a_ext < alt0_ext || a_ext > alt1_ext || alt1 <= alt0) begin
            state <= ST_OUT;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (dcnt == tbi_pkg::DCNT_W'(tbi_pkg::DIV_STEPS - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      if (pop_item.op == tbi_pkg::OP_WRITE) begin
        tbl[pop_item.idx] <= {pop_item.alt, pop_item.pitch};
      end else begin
        qalt   <= pop_item.qalt;
        n_used <= n_clamp;
      end
    end
    if (state == ST_RD) begin
      rd0 <= tbl[cur_seg];
      rd1 <= tbl[seg_p1];
    end
    if (state == ST_CHK) begin
      da   <= da_full[tbi_pkg::ALT_W-1:0];
      dalt <= alt1 - alt0;
      dp   <= {p1[tbi_pkg::PITCH_W-1], p1} - {p0[tbi_pkg::PITCH_W-1], p0};
      priority if (a_ext < alt0_ext) begin
        res_pitch  <= p0;
        res_region <= tbi_pkg::REGION_BELOW;
      end else if (a_ext > alt1_ext) begin
        res_pitch  <= p1;
        res_region <= tbi_pkg::REGION_ABOVE;
      end else begin
        res_pitch  <= p0;
        res_region <= tbi_pkg::REGION_INTERP;
      end
    end
    if (state == ST_MUL) begin
      neg  <= dp[tbi_pkg::DIFF_W-1];
      rem  <= {1'b0, prod[tbi_pkg::PROD_W-1:tbi_pkg::DIV_STEPS]};
      wq   <= prod[tbi_pkg::DIV_STEPS-1:0];
      dcnt <= '0;
    end
    if (state == ST_DIV) begin
      rem  <= ge ? trial_sub[tbi_pkg::ALT_W-1:0] : trial[tbi_pkg::ALT_W-1:0];
      wq   <= {wq[tbi_pkg::DIV_STEPS-2:0], ge};
      dcnt <= dcnt + 1'b1;
    end
    if (state == ST_FIN) begin
      res_pitch <= sum[tbi_pkg::PITCH_W-1:0];
    end
    if (state == ST_OUT && out_free) begin
      m_tdata <= {{tbi_pkg::OUT_PAD_W{1'b0}}, res_region, cur_seg, res_pitch};
    end
  end

endmodule

@@ hw/rtl/tbi_checker.sv @@
module tbi_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [tbi_pkg::M_TDATA_W-1:0] m_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // the lower breakpoint of a segment is never the last slot
  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[tbi_pkg::PITCH_W +: tbi_pkg::IDX_W] != {tbi_pkg::IDX_W{1'b1}})
    else $error("segment index out of range");

  // no result and an open request side right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> s_tready)
    else $error("request side not ready after reset");

endmodule

bind tracked_breakpoint_interpolator tbi_checker u_tbi_checker (.*);

@@ tb/sv/tb_tracked_breakpoint_interpolator.sv @@
`timescale 1ns / 1ps

module tb_tracked_breakpoint_interpolator;

  localparam int RESET_CYCLES    = 11;
  localparam int ITEM_TARGET     = 1650;
  localparam int PITCH_LIMIT     = 205887;    // pi in Q2.16
  localparam int ALT_MAX         = 8388607;
  localparam int QALT_MAX        = 8388607;
  localparam int QALT_MIN        = -8388608;
  localparam int SETTLE_CYCLES   = 80;
  localparam int LONG_HOLD       = 600;       // result side held off while requests pile up
  localparam int WATCHDOG_CYCLES = 4000;      // cycles with no handshake of any kind

  // request field offsets inside tdata
  localparam int ALT_LSB   = tbi_pkg::IDX_W;
  localparam int PITCH_LSB = ALT_LSB + tbi_pkg::ALT_W;
  localparam int QALT_LSB  = PITCH_LSB + tbi_pkg::PITCH_W;

  // one result as it leaves the block
  typedef struct packed {
    logic signed [tbi_pkg::PITCH_W-1:0] pitch;
    logic [tbi_pkg::IDX_W-1:0]          seg;
    logic [tbi_pkg::REG_W-1:0]          region;
  } pitch_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [tbi_pkg::S_TDATA_W-1:0] s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [tbi_pkg::M_TDATA_W-1:0] m_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tbi_pkg::CNT_W-1:0]     cfg_data = '0;

  // request stream, filled by the stimulus and drained by the driver
  tbi_pkg::item_t requests_to_send [$];
  tbi_pkg::item_t next_req;
  bit    sender_busy = 1'b0;
  int    gap_left = 0;
  bit    tx_calm = 1'b0;

  // result side pacing
  int    stall_left = 0;
  int    hold_left = 0;
  int    hold_request = 0;
  bit    rx_calm = 1'b0;

  // handshakes seen at the last rising edge, used by the falling-edge processes
  bit    req_fire = 1'b0;
  bit    rsp_fire = 1'b0;

  // predictor state: breakpoint table, entry count and the tracked segment
  logic [tbi_pkg::ALT_W-1:0]          table_alt [tbi_pkg::MAX_ENTRIES];
  logic signed [tbi_pkg::PITCH_W-1:0] table_pitch [tbi_pkg::MAX_ENTRIES];
  logic [tbi_pkg::CNT_W-1:0]          count_reg = tbi_pkg::CNT_RESET;
  int                                 tracked_segment = 0;
  pitch_result_t                      pitches_due [$];

  // what the stimulus believes the table looks like, for aiming queries
  int    plan_alt [tbi_pkg::MAX_ENTRIES];
  int    plan_count = 2;

  int    queued_items = 0;
  int    phase_count = 0;
  int    mismatches = 0;
  int    queries_checked = 0;
  int    table_writes = 0;
  int    count_writes = 0;
  int    region_hits [3] = '{0, 0, 0};
  int    idle_cycles = 0;

  tracked_breakpoint_interpolator u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one line per mismatch, and a running count
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %0s: got %0d, expected %0d, at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // walk the tracked segment to the altitude, then clamp or interpolate
  function automatic pitch_result_t interpolate_pitch(
    input logic signed [tbi_pkg::QALT_W-1:0] qalt);
    int            n;
    int            s;
    longint        a;
    longint        a0;
    longint        a1;
    longint        p0;
    longint        p1;
    longint        pitch;
    pitch_result_t r;
    // count outside 2..16 is pinned to the nearest legal value
    n = (count_reg < tbi_pkg::CNT_MIN) ? 2 :
        (count_reg > tbi_pkg::CNT_MAX) ? tbi_pkg::MAX_ENTRIES : int'(count_reg);
    a = qalt;
    // count may have shrunk since the segment was last used
    s = (tracked_segment > n - 2) ? n - 2 : tracked_segment;
    while (s + 1 < n - 1 && longint'(table_alt[s + 1]) <= a) s++;
    while (s > 0 && longint'(table_alt[s]) > a) s--;
    tracked_segment = s;
    a0 = table_alt[s];
    a1 = table_alt[s + 1];
    p0 = table_pitch[s];
    p1 = table_pitch[s + 1];
    if (a < a0) begin
      pitch = p0;
      r.region = tbi_pkg::REGION_BELOW;
    end else if (a > a1) begin
      pitch = p1;
      r.region = tbi_pkg::REGION_ABOVE;
    end else begin
      r.region = tbi_pkg::REGION_INTERP;
      // flat or backward segment gives the lower pitch, no divide
      pitch = (a1 > a0) ? p0 + (a - a0) * (p1 - p0) / (a1 - a0) : p0;
    end
    r.pitch = tbi_pkg::PITCH_W'(pitch);
    r.seg = tbi_pkg::IDX_W'(s);
    return r;
  endfunction

  function automatic int rand_pitch();
    return int'($urandom_range(0, 2 * PITCH_LIMIT)) - PITCH_LIMIT;
  endfunction

  // table write request; the unused query altitude carries noise
  function automatic void queue_entry(input int slot, input int alt, input int pitch);
    tbi_pkg::item_t it;
    it.op = tbi_pkg::OP_WRITE;
    it.idx = tbi_pkg::IDX_W'(slot);
    it.alt = tbi_pkg::ALT_W'(alt);
    it.pitch = tbi_pkg::PITCH_W'(pitch);
    it.qalt = tbi_pkg::QALT_W'($urandom);
    requests_to_send = {requests_to_send, it};
    plan_alt[slot] = alt;
    queued_items++;
  endfunction

  // query request; the unused entry fields carry noise
  function automatic void queue_query(input int qalt);
    tbi_pkg::item_t it;
    it.op = tbi_pkg::OP_QUERY;
    it.idx = tbi_pkg::IDX_W'($urandom);
    it.alt = tbi_pkg::ALT_W'($urandom);
    it.pitch = tbi_pkg::PITCH_W'($urandom);
    it.qalt = tbi_pkg::QALT_W'(qalt);
    requests_to_send = {requests_to_send, it};
    queued_items++;
  endfunction

  // sender drained, every result back, then let trailing writes land
  task automatic wait_for_idle();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || sender_busy || pitches_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // entry count is only changed with the block idle
  task automatic program_count(input int value);
    wait_for_idle();
    cfg_valid <= 1'b1;
    cfg_data <= tbi_pkg::CNT_W'(value);
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    plan_count = (value < 2) ? 2 : (value > tbi_pkg::MAX_ENTRIES) ? tbi_pkg::MAX_ENTRIES : value;
  endtask

  // request driver: holds a request until taken, then waits its drawn gap
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      sender_busy = 1'b0;
      gap_left = 0;
    end else if (!s_tvalid || req_fire) begin
      if (s_tvalid)
        gap_left = tx_calm ? 0 : $urandom_range(0, 18);
      if (gap_left == 0 && requests_to_send.size() != 0) begin
        next_req = requests_to_send.pop_front();
        // tdata from bit 0: entry_index, entry_altitude, entry_pitch, query_altitude
        s_tdata <= {{(tbi_pkg::S_TDATA_W - tbi_pkg::S_FIELDS_W){1'b0}}, next_req.qalt,
                    next_req.pitch, next_req.alt, next_req.idx};
        s_tuser <= next_req.op;
        s_tvalid <= 1'b1;
        sender_busy = 1'b1;
      end else begin
        s_tvalid <= 1'b0;
        sender_busy = 1'b0;
        if (gap_left > 0)
          gap_left--;
      end
    end
  end

  // result side: a drawn stall after each result, plus an occasional long hold-off
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (rsp_fire)
        stall_left = rx_calm ? 0 : $urandom_range(0, 18);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // monitor: tracks config and table writes, predicts queries, checks results
  always @(posedge clk) begin
    pitch_result_t got;
    pitch_result_t want;
    req_fire = !rst && s_tvalid && s_tready;
    rsp_fire = !rst && m_tvalid && m_tready;
    if (rst) begin
      count_reg = tbi_pkg::CNT_RESET;
      tracked_segment = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count_reg = cfg_data;
        count_writes++;
      end
      if (req_fire) begin
        if (s_tuser == tbi_pkg::OP_WRITE) begin
          table_alt[s_tdata[0 +: tbi_pkg::IDX_W]] = s_tdata[ALT_LSB +: tbi_pkg::ALT_W];
          table_pitch[s_tdata[0 +: tbi_pkg::IDX_W]] = s_tdata[PITCH_LSB +: tbi_pkg::PITCH_W];
          table_writes++;
        end else begin
          pitches_due = {pitches_due,
                         interpolate_pitch(s_tdata[QALT_LSB +: tbi_pkg::QALT_W])};
        end
      end
      if (rsp_fire) begin
        // tdata from bit 0: target_pitch, segment, region
        got.pitch = m_tdata[0 +: tbi_pkg::PITCH_W];
        got.seg = m_tdata[tbi_pkg::PITCH_W +: tbi_pkg::IDX_W];
        got.region = m_tdata[tbi_pkg::PITCH_W + tbi_pkg::IDX_W +: tbi_pkg::REG_W];
        if (pitches_due.size() == 0) begin
          report_mismatch("result with no query outstanding", m_tdata, 0);
        end else begin
          want = pitches_due.pop_front();
          if (got.pitch !== want.pitch)
            report_mismatch("target_pitch", got.pitch, want.pitch);
          if (got.seg !== want.seg)
            report_mismatch("segment", got.seg, want.seg);
          if (got.region !== want.region)
            report_mismatch("region", got.region, want.region);
          queries_checked++;
          region_hits[want.region]++;
        end
      end
      // watchdog on handshake activity
      if (req_fire || rsp_fire || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("no handshake for %0d cycles, giving up", WATCHDOG_CYCLES);
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int style;
    int step_max;
    int alt_now;
    int slot;
    int lo;
    int hi;
    int margin;
    int qalt;
    int value;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: entries 0 and 1 share altitude 0, entries 14 and 15 sit at the top,
    // pitches cycle through both extremes and zero-ish values
    for (int i = 0; i < tbi_pkg::MAX_ENTRIES; i++)
      queue_entry(i, (i < 2) ? 0 : (i >= 14) ? ALT_MAX : i * 600000,
                  (i % 3 == 0) ? PITCH_LIMIT : (i % 3 == 1) ? -PITCH_LIMIT : i * 1000);
    // reset count of two: below the table, flat first segment, above it
    queue_query(QALT_MIN);
    queue_query(0);
    queue_query(5);
    // full table: interpolate low and mid, then the flat top segment at max altitude
    program_count(tbi_pkg::MAX_ENTRIES);
    queue_query(300000);
    queue_query(4000000);
    queue_query(QALT_MAX);
    // break the ordering and query across the broken spot
    queue_entry(5, 100, 0);
    queue_query(3000000);
    // count below range while the tracked segment is still high
    program_count(0);
    queue_query(5);
    // count above range
    program_count(31);
    queue_query(4000000);

    // random phases
    while (queued_items < ITEM_TARGET) begin
      phase_count++;
      tx_calm = ($urandom_range(0, 4) == 0);
      rx_calm = ($urandom_range(0, 4) == 0);

      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 7))
          0: value = 2;
          1: value = tbi_pkg::MAX_ENTRIES;
          2: value = $urandom_range(0, 1);
          3: value = $urandom_range(tbi_pkg::MAX_ENTRIES + 1, 31);
          default: value = $urandom_range(3, tbi_pkg::MAX_ENTRIES - 1);
        endcase
        program_count(value);
      end

      // reload: mostly sorted, sometimes with many repeats, now and then unsorted
      if (phase_count == 1 || $urandom_range(0, 3) == 0) begin
        style = $urandom_range(0, 5);
        step_max = $urandom_range(0, 1) ? ALT_MAX / tbi_pkg::MAX_ENTRIES
                                        : $urandom_range(1, 2000);
        alt_now = $urandom_range(0, step_max);
        for (int i = 0; i < tbi_pkg::MAX_ENTRIES; i++) begin
          if (style == 5)
            alt_now = $urandom_range(0, ALT_MAX);
          else if (i > 0 && !(style >= 3 && $urandom_range(0, 2) == 0))
            alt_now += $urandom_range(0, step_max);
          queue_entry(i, alt_now, rand_pitch());
        end
      end

      // hold the result side off while requests keep coming so the block backs up
      if (phase_count == 3) begin
        tx_calm = 1'b1;
        hold_request = LONG_HOLD;
      end

      repeat ($urandom_range(40, 110)) begin
        if ($urandom_range(0, 11) == 0) begin
          // rewrite one entry between its neighbors so a sorted table stays sorted
          slot = $urandom_range(0, tbi_pkg::MAX_ENTRIES - 1);
          lo = (slot == 0) ? 0 : plan_alt[slot - 1];
          hi = (slot == tbi_pkg::MAX_ENTRIES - 1) ? ALT_MAX : plan_alt[slot + 1];
          queue_entry(slot, (lo <= hi) ? lo + int'($urandom_range(0, hi - lo))
                                       : int'($urandom_range(0, ALT_MAX)), rand_pitch());
        end else begin
          lo = plan_alt[0];
          hi = lo;
          for (int i = 1; i < plan_count; i++) begin
            if (plan_alt[i] < lo) lo = plan_alt[i];
            if (plan_alt[i] > hi) hi = plan_alt[i];
          end
          case ($urandom_range(0, 9))
            0: qalt = int'($signed(tbi_pkg::QALT_W'($urandom)));
            1: qalt = $urandom_range(0, 1) ? QALT_MAX : QALT_MIN;
            2, 3: qalt = plan_alt[$urandom_range(0, plan_count - 1)]
                         + int'($urandom_range(0, 2)) - 1;
            default: begin
              // mostly inside the used span, with some spill past both ends
              margin = (hi - lo) / 8 + 16;
              qalt = lo - margin + int'($urandom_range(0, hi - lo + 2 * margin));
            end
          endcase
          if (qalt > QALT_MAX)
            qalt = QALT_MAX;
          queue_query(qalt);
        end
      end
      // sender pauses here until every result of the phase is back
      wait_for_idle();
    end

    $display("checked %0d queries (%0d interpolated, %0d below, %0d above), %0d table writes",
             queries_checked, region_hits[tbi_pkg::REGION_INTERP],
             region_hits[tbi_pkg::REGION_BELOW], region_hits[tbi_pkg::REGION_ABOVE],
             table_writes);
    $display("%0d entry count writes over %0d phases, %0d mismatches",
             count_writes, phase_count, mismatches);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
